// ===== sv/hsv2rgb_pkg.sv =====
// shared types and constants for the hsv to rgb converter
package hsv2rgb_pkg;

  localparam int CH_W    = 17;
  localparam int HUE_W   = 16;
  localparam int TDATA_W = 72;

  typedef enum logic [2:0] {
    SEC_RED     = 3'd0,
    SEC_YELLOW  = 3'd1,
    SEC_GREEN   = 3'd2,
    SEC_CYAN    = 3'd3,
    SEC_BLUE    = 3'd4,
    SEC_MAGENTA = 3'd5
  } sector_t;

  typedef struct packed {
    sector_t          sector;
    logic [CH_W-1:0]  v;
    logic [CH_W-1:0]  p;
    logic [CH_W-1:0]  q;
    logic [CH_W-1:0]  t;
  } prod_t;

  typedef struct packed {
    logic [CH_W-1:0] red;
    logic [CH_W-1:0] green;
    logic [CH_W-1:0] blue;
  } rgb_t;

endpackage

// ===== sv/hsv2rgb_sel.sv =====
// sector based channel selection of v, p, q and t
module hsv2rgb_sel (
  input  hsv2rgb_pkg::prod_t prod,
  output hsv2rgb_pkg::rgb_t  rgb
);

  always_comb begin
    case (prod.sector)
      hsv2rgb_pkg::SEC_RED: begin
        rgb.red   = prod.v;
        rgb.green = prod.t;
        rgb.blue  = prod.p;
      end
      hsv2rgb_pkg::SEC_YELLOW: begin
        rgb.red   = prod.q;
        rgb.green = prod.v;
        rgb.blue  = prod.p;
      end
      hsv2rgb_pkg::SEC_GREEN: begin
        rgb.red   = prod.p;
        rgb.green = prod.v;
        rgb.blue  = prod.t;
      end
      hsv2rgb_pkg::SEC_CYAN: begin
        rgb.red   = prod.p;
        rgb.green = prod.q;
        rgb.blue  = prod.v;
      end
      hsv2rgb_pkg::SEC_BLUE: begin
        rgb.red   = prod.t;
        rgb.green = prod.p;
        rgb.blue  = prod.v;
      end
      default: begin
        rgb.red   = prod.v;
        rgb.green = prod.p;
        rgb.blue  = prod.q;
      end
    endcase
  end

endmodule

// ===== sv/hsv_to_rgb_converter.sv =====
// hsv to rgb converter top level, four register stages
// path: an accepted request is registered in stage 1, stage 2, stage 3 and the output register in turn
// throughput: one request per cycle while the output is not stalled, set by the two multiplier stages
// a stalled output holds every stage that has no empty stage after it; empty stages fill while stalled
// reset: synchronous, clears all stage valid bits, payload is not reset
module hsv_to_rgb_converter #(
  parameter int FRAC_BITS = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // hue[15:0], saturation[32:16], brightness[49:33], opacity[66:50], zero pad
  input  logic [71:0] s_axis_tdata,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // red[16:0], green[33:17], blue[50:34], opacity_out[67:51], zero pad
  output logic [71:0] m_axis_tdata
);

  localparam int CW   = hsv2rgb_pkg::CH_W;
  localparam int HW   = hsv2rgb_pkg::HUE_W;
  localparam int OW   = FRAC_BITS + 1;
  localparam int MW   = (CW > OW) ? CW : OW;
  localparam int H6W  = HW + 3;
  localparam int SFW  = CW + FRAC_BITS;
  localparam int PW   = CW + OW;
  localparam int PAD  = hsv2rgb_pkg::TDATA_W - 4 * CW;
  localparam logic [OW-1:0] ONE = {1'b1, {FRAC_BITS{1'b0}}};

  // input unpack and clamping
  logic [HW-1:0]        hue;
  logic [CW-1:0]        saturation;
  logic [CW-1:0]        brightness;
  logic [CW-1:0]        opacity;
  logic [CW-1:0]        s_clamp;
  logic [CW-1:0]        v_clamp;
  logic [H6W-1:0]       h6;
  logic [HW-1:0]        f16;
  logic [FRAC_BITS-1:0] f;

  assign hue        = s_axis_tdata[HW-1:0];
  assign saturation = s_axis_tdata[HW +: CW];
  assign brightness = s_axis_tdata[HW + CW +: CW];
  assign opacity    = s_axis_tdata[HW + 2*CW +: CW];

  assign s_clamp = (MW'(saturation) > MW'(ONE)) ? CW'(ONE) : saturation;
  assign v_clamp = (MW'(brightness) > MW'(ONE)) ? CW'(ONE) : brightness;
  assign h6      = H6W'(hue) * H6W'(6);
  assign f16     = h6[HW-1:0];

  generate
    if (FRAC_BITS >= HW) begin : g_f_up
      assign f = FRAC_BITS'(f16) << (FRAC_BITS - HW);
    end else begin : g_f_down
      assign f = FRAC_BITS'(f16 >> (HW - FRAC_BITS));
    end
  endgenerate

  // stage control
  logic st1_valid, st2_valid, st3_valid, out_valid;
  logic rdy1, rdy2, rdy3, rdy_out;

  assign rdy_out       = !out_valid || m_axis_tready;
  assign rdy3          = !st3_valid || rdy_out;
  assign rdy2          = !st2_valid || rdy3;
  assign rdy1          = !st1_valid || rdy2;
  assign s_axis_tready = rdy1;
  assign m_axis_tvalid = out_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      st1_valid <= 1'b0;
      st2_valid <= 1'b0;
      st3_valid <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (rdy1)    st1_valid <= s_axis_tvalid;
      if (rdy2)    st2_valid <= st1_valid;
      if (rdy3)    st3_valid <= st2_valid;
      if (rdy_out) out_valid <= st3_valid;
    end
  end

  // stage 1 registers: sector, fraction, clamped saturation and brightness, opacity
  hsv2rgb_pkg::sector_t st1_sector;
  logic [FRAC_BITS-1:0] st1_f;
  logic [CW-1:0]        st1_s;
  logic [CW-1:0]        st1_v;
  logic [CW-1:0]        st1_a;

  always_ff @(posedge clk) begin
    if (rdy1 && s_axis_tvalid) begin
      st1_sector <= hsv2rgb_pkg::sector_t'(h6[H6W-1:HW]);
      st1_f      <= f;
      st1_s      <= s_clamp;
      st1_v      <= v_clamp;
      st1_a      <= opacity;
    end
  end

  // stage 2: s*f, s*(1-f), 1-s
  logic [OW-1:0]  omf;
  logic [SFW-1:0] sf_prod;
  logic [PW-1:0]  s1f_prod;

  assign omf      = ONE - OW'(st1_f);
  assign sf_prod  = SFW'(st1_s) * SFW'(st1_f);
  assign s1f_prod = PW'(st1_s) * PW'(omf);

  hsv2rgb_pkg::sector_t st2_sector;
  logic [CW-1:0]        st2_sf;
  logic [CW-1:0]        st2_s1f;
  logic [OW-1:0]        st2_oms;
  logic [CW-1:0]        st2_v;
  logic [CW-1:0]        st2_a;

  always_ff @(posedge clk) begin
    if (rdy2 && st1_valid) begin
      st2_sector <= st1_sector;
      st2_sf     <= sf_prod[FRAC_BITS +: CW];
      st2_s1f    <= s1f_prod[FRAC_BITS +: CW];
      st2_oms    <= ONE - OW'(st1_s);
      st2_v      <= st1_v;
      st2_a      <= st1_a;
    end
  end

  // stage 3: p, q, t
  logic [OW-1:0] omq;
  logic [OW-1:0] omt;
  logic [PW-1:0] p_prod;
  logic [PW-1:0] q_prod;
  logic [PW-1:0] t_prod;

  assign omq    = ONE - OW'(st2_sf);
  assign omt    = ONE - OW'(st2_s1f);
  assign p_prod = PW'(st2_v) * PW'(st2_oms);
  assign q_prod = PW'(st2_v) * PW'(omq);
  assign t_prod = PW'(st2_v) * PW'(omt);

  hsv2rgb_pkg::prod_t st3_prod;
  logic [CW-1:0]      st3_a;

  always_ff @(posedge clk) begin
    if (rdy3 && st2_valid) begin
      st3_prod.sector <= st2_sector;
      st3_prod.v      <= st2_v;
      st3_prod.p      <= p_prod[FRAC_BITS +: CW];
      st3_prod.q      <= q_prod[FRAC_BITS +: CW];
      st3_prod.t      <= t_prod[FRAC_BITS +: CW];
      st3_a           <= st2_a;
    end
  end

  // stage 4: channel select into output register
  hsv2rgb_pkg::rgb_t rgb_sel;
  hsv2rgb_pkg::rgb_t out_rgb;
  logic [CW-1:0]     out_a;

  hsv2rgb_sel u_sel (
    .prod (st3_prod),
    .rgb  (rgb_sel)
  );

  always_ff @(posedge clk) begin
    if (rdy_out && st3_valid) begin
      out_rgb <= rgb_sel;
      out_a   <= st3_a;
    end
  end

  assign m_axis_tdata = {{PAD{1'b0}}, out_a, out_rgb.blue, out_rgb.green, out_rgb.red};

`ifndef SYNTHESIS
  a_accept_fills_stage1: assert property (@(posedge clk) disable iff (rst)
    s_axis_tvalid && s_axis_tready |=> st1_valid)
    else $error("accepted request did not reach stage 1");

  a_backpressure_only_when_full: assert property (@(posedge clk) disable iff (rst)
    !s_axis_tready |-> st1_valid && st2_valid && st3_valid && out_valid)
    else $error("input stalled with an empty stage");

  a_helpers_bounded: assert property (@(posedge clk) disable iff (rst)
    st3_valid |-> st3_prod.p <= st3_prod.v && st3_prod.q <= st3_prod.v &&
                  st3_prod.t <= st3_prod.v)
    else $error("helper value exceeds brightness");
`endif

endmodule
